@@ hw/rtl/bsed_pkg.sv @@
// Shared types, constants and a helper function of the backslash escape decoder.
package bsed_pkg;

    localparam int unsigned NumOut    = 5;   // most bytes one input byte can cause
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QPtrW     = $clog2(QueueDepth);
    localparam int unsigned OutCntW   = $clog2(NumOut + 1);

    // Characters that steer the decoding.
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChN      = 8'h6E;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] ChX      = 8'h78;
    localparam logic [7:0] ChU      = 8'h75;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChTab    = 8'h09;

    // UTF-8 lead and continuation marks.
    localparam logic [7:0] Utf8Lead2 = 8'hC0;
    localparam logic [7:0] Utf8Lead3 = 8'hE0;
    localparam logic [7:0] Utf8Cont  = 8'h80;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BSL  = 3'b010,
        PH_HEX  = 3'b100
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [3:0] val;
    } t_hex;

    // One decoded group: the bytes that one input byte causes.
    typedef struct packed {
        logic [NumOut-1:0][7:0] bytes;
        logic [OutCntW-1:0]     count;
        logic                   fin;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex r;
        r.valid = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = 4'(c - 8'h37);
        end else begin
            r.valid = 1'b0;
            r.val   = 4'd0;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/bsed_front.sv @@
// Front end: tracks escape state and turns each input byte into a group of output bytes.
module bsed_front
    import bsed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_fin,
    output t_job       o_job
);

    t_phase     r_phase, n_phase;
    logic       r_kind, n_kind;
    logic [1:0] r_hcnt, n_hcnt;
    logic [7:0] r_held [3];
    logic [7:0] n_held [3];

    t_hex        hv;
    logic [7:0]  letter;
    logic        fresh_bs;
    logic [1:0]  need_last;
    logic [15:0] code;

    always_comb begin
        hv        = hex_val(i_byte);
        letter    = r_kind ? ChU : ChX;
        fresh_bs  = (i_byte == ChBslash) && !i_fin;
        need_last = r_kind ? 2'd3 : 2'd1;
        code      = {hex_val(r_held[0]).val, hex_val(r_held[1]).val,
                     hex_val(r_held[2]).val, hv.val};

        n_phase = PH_IDLE;
        n_kind  = r_kind;
        n_hcnt  = 2'd0;
        n_held  = r_held;

        o_job.bytes    = '0;
        o_job.bytes[0] = i_byte;
        o_job.count    = '0;
        o_job.fin      = i_fin;

        case (r_phase)
            PH_BSL: begin
                if (i_byte == ChN) begin
                    o_job.bytes[0] = ChLf;
                    o_job.count    = OutCntW'(1);
                end else if (i_byte == ChR) begin
                    o_job.bytes[0] = ChCr;
                    o_job.count    = OutCntW'(1);
                end else if (i_byte == ChT) begin
                    o_job.bytes[0] = ChTab;
                    o_job.count    = OutCntW'(1);
                end else if ((i_byte == ChX || i_byte == ChU) && !i_fin) begin
                    n_phase = PH_HEX;
                    n_kind  = (i_byte == ChU);
                end else begin
                    o_job.count = OutCntW'(1);
                end
            end
            PH_HEX: begin
                if (hv.valid && r_hcnt == need_last) begin
                    // Escape complete: one byte for x, UTF-8 for u.
                    if (!r_kind) begin
                        o_job.bytes[0] = {hex_val(r_held[0]).val, hv.val};
                        o_job.count    = OutCntW'(1);
                    end else if (code[15:7] == '0) begin
                        o_job.bytes[0] = {1'b0, code[6:0]};
                        o_job.count    = OutCntW'(1);
                    end else if (code[15:11] == '0) begin
                        o_job.bytes[0] = Utf8Lead2 | {3'b000, code[10:6]};
                        o_job.bytes[1] = Utf8Cont | {2'b00, code[5:0]};
                        o_job.count    = OutCntW'(2);
                    end else begin
                        o_job.bytes[0] = Utf8Lead3 | {4'b0000, code[15:12]};
                        o_job.bytes[1] = Utf8Cont | {2'b00, code[11:6]};
                        o_job.bytes[2] = Utf8Cont | {2'b00, code[5:0]};
                        o_job.count    = OutCntW'(3);
                    end
                end else if (hv.valid && !i_fin) begin
                    n_held[r_hcnt] = i_byte;
                    n_hcnt         = r_hcnt + 2'd1;
                    n_phase        = PH_HEX;
                end else begin
                    // Bad or cut-short escape: replay the letter and held digits,
                    // then treat this byte as a fresh one.
                    o_job.bytes[0] = letter;
                    o_job.bytes[1] = r_held[0];
                    o_job.bytes[2] = r_held[1];
                    o_job.bytes[3] = r_held[2];
                    case (r_hcnt)
                        2'd0:    o_job.bytes[1] = i_byte;
                        2'd1:    o_job.bytes[2] = i_byte;
                        2'd2:    o_job.bytes[3] = i_byte;
                        default: o_job.bytes[4] = i_byte;
                    endcase
                    o_job.count = OutCntW'(r_hcnt) + OutCntW'(1)
                                + (fresh_bs ? OutCntW'(0) : OutCntW'(1));
                    n_phase = fresh_bs ? PH_BSL : PH_IDLE;
                end
            end
            default: begin
                if (fresh_bs) begin
                    n_phase = PH_BSL;
                end else begin
                    o_job.count = OutCntW'(1);
                end
            end
        endcase

        if (i_fin) begin
            n_phase = PH_IDLE;
            n_hcnt  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= 1'b0;
            r_hcnt  <= 2'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_hcnt  <= n_hcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held <= n_held;
        end
    end

endmodule

@@ hw/rtl/bsed_queue.sv @@
// Short queue of decoded byte groups between the front end and the back end.
module bsed_queue
    import bsed_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [QPtrW:0]   r_cnt;

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = (r_cnt == (QPtrW+1)'(QueueDepth));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPtrW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPtrW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

@@ hw/rtl/bsed_back.sv @@
// Back end: sends the bytes of each queued group out one transaction at a time.
module bsed_back
    import bsed_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  logic    i_empty,
    output logic    o_pop,
    output logic    o_valid,
    output logic [7:0] o_byte,
    output logic    o_last,
    output logic    o_end,
    input  logic    i_ready
);

    logic               r_valid;
    t_job               r_job;
    logic [OutCntW-1:0] r_idx;
    logic               is_last, hs, load;

    assign is_last = (r_idx == r_job.count - OutCntW'(1));
    assign hs      = r_valid && i_ready;
    assign load    = !r_valid || (hs && is_last);
    assign o_pop   = load && !i_empty;

    assign o_valid = r_valid;
    assign o_byte  = r_job.bytes[r_idx];
    assign o_last  = is_last;
    assign o_end   = is_last && r_job.fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_idx   <= '0;
        end else if (hs) begin
            r_idx <= r_idx + OutCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

endmodule

@@ hw/rtl/backslash_escape_decoder.sv @@
// Top level of the backslash escape decoder.
//
// The block reads an escaped string on the slave stream, one character per
// transaction, with tlast high on the final character of the string. It
// writes the unescaped bytes on the master stream, one byte per transaction.
// Master tlast marks the last byte caused by one input character, and master
// tuser marks the final decoded byte of the whole string. Some characters
// cause no output at all (a backslash, or a hex digit of an escape still
// being collected); a character can cause up to five bytes.
// The front end classifies each character and registers the resulting group
// of bytes into a four-deep queue; the back end drains the queue one byte per
// cycle while the receiver is ready. The first byte of a group is stored in
// the queue and then loaded into the back-end register before it is valid on
// the master port. The input side takes one character per cycle as long as
// the queue has room, so the sustained rate is set by the single output port.
// When the receiver stalls, the current byte holds on the master port, the
// queue fills, and slave tready falls once four groups wait behind the one
// being sent. Reset clears the escape state, the queue and the output valid.
module backslash_escape_decoder
    import bsed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // is_final
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // run_last
    output logic       o_m_axis_tuser    // [0] string_end
);

    t_job    front_job, head_job;
    t_q_stat q_stat;
    logic    accept, push, pop;

    // A new character is taken whenever the queue can hold its group.
    assign o_s_axis_tready = !q_stat.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    // Groups with no bytes never enter the queue.
    assign push            = accept && (front_job.count != '0);

    bsed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_fin    (i_s_axis_tlast),
        .o_job    (front_job)
    );

    bsed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    bsed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (q_stat.empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .o_end   (o_m_axis_tuser),
        .i_ready (i_m_axis_tready)
    );

endmodule

@@ verif/tb_backslash_escape_decoder.sv @@
// Self-checking testbench for the backslash escape decoder with directed and random strings.
`timescale 1ns / 100ps

module tb_backslash_escape_decoder;
    import bsed_pkg::*;

    // One decoded byte as it should appear on the master stream.
    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       str_end;
    } t_decoded;

    localparam int unsigned ItemTarget = 270;     // random input bytes to offer
    localparam int unsigned HoldCycles = 300;     // length of the long receiver hold-off
    localparam int unsigned DrainTail  = 20;      // settle time after the last byte
    localparam realtime     RunLimit   = 2_000_000ns;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic       i_s_axis_tlast  = 1'b0;   // is_final
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] out_byte
    logic       o_m_axis_tlast;           // run_last
    logic       o_m_axis_tuser;           // [0] string_end

    // Decoder state as the testbench expects it to be.
    t_phase     esc_phase = PH_IDLE;
    logic       esc_is_u  = 1'b0;
    logic [7:0] held_digits [4];
    int         held_n    = 0;

    t_decoded   pending_out [$];          // decoded bytes still to come out of the block

    // Sender and receiver pacing.
    logic        tx_bursty    = 1'b0;
    int          burst_left   = 0;
    logic        rx_stalls    = 1'b0;
    logic [15:0] rx_pattern   = 16'hFFFF;
    int          rx_cycle     = 0;
    logic        hold_request = 1'b0;
    int          hold_left    = 0;

    // Run statistics.
    int fail_count    = 0;
    int items_offered = 0;
    int strings_sent  = 0;
    int bytes_checked = 0;
    int silent_items  = 0;
    int full_groups   = 0;

    backslash_escape_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1ns i_clk = ~i_clk;
    end

    // Value of a hex digit character, or -1 when the character is not one.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;   // 0 to 9
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;   // a to f
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;   // A to F
        return -1;
    endfunction

    // Appends one byte at the end of a byte queue.
    function automatic void put_byte(ref logic [7:0] q [$], input logic [7:0] b);
        q.insert(q.size(), b);
    endfunction

    // Works out the bytes that one accepted input transaction causes, updates the
    // expected escape state and queues the bytes with their tlast and tuser flags.
    task automatic predict_decode(input logic [7:0] ch, input logic fin);
        logic [7:0]  outs [$];
        logic [15:0] cp;
        logic        fresh;
        int          nib;
        int          need;
        t_decoded    d;
        fresh = 1'b0;
        case (esc_phase)
            PH_BSL: begin
                esc_phase = PH_IDLE;
                if (ch == ChN) begin
                    put_byte(outs, ChLf);
                end else if (ch == ChR) begin
                    put_byte(outs, ChCr);
                end else if (ch == ChT) begin
                    put_byte(outs, ChTab);
                end else if (ch == ChX || ch == ChU) begin
                    // An escape letter that ends the string comes out alone.
                    if (fin) begin
                        put_byte(outs, ch);
                    end else begin
                        esc_phase = PH_HEX;
                        esc_is_u  = (ch == ChU);
                        held_n    = 0;
                    end
                end else begin
                    put_byte(outs, ch);
                end
            end
            PH_HEX: begin
                need = esc_is_u ? 4 : 2;
                nib  = hex_nibble(ch);
                if (nib >= 0 && held_n + 1 == need) begin
                    cp = '0;
                    for (int j = 0; j < held_n; j++) begin
                        cp = {cp[11:0], 4'(hex_nibble(held_digits[j]))};
                    end
                    cp = {cp[11:0], 4'(nib)};
                    if (!esc_is_u || cp < 16'h0080) begin
                        put_byte(outs, cp[7:0]);
                    end else if (cp < 16'h0800) begin
                        put_byte(outs, Utf8Lead2 | {3'b000, cp[10:6]});
                        put_byte(outs, Utf8Cont | {2'b00, cp[5:0]});
                    end else begin
                        put_byte(outs, Utf8Lead3 | {4'b0000, cp[15:12]});
                        put_byte(outs, Utf8Cont | {2'b00, cp[11:6]});
                        put_byte(outs, Utf8Cont | {2'b00, cp[5:0]});
                    end
                    esc_phase = PH_IDLE;
                    held_n    = 0;
                end else if (nib >= 0 && !fin) begin
                    held_digits[held_n] = ch;
                    held_n++;
                end else begin
                    // A bad digit or an early end gives back the letter and the digits
                    // so far, and the current character is then decoded on its own.
                    put_byte(outs, esc_is_u ? ChU : ChX);
                    for (int j = 0; j < held_n; j++) begin
                        put_byte(outs, held_digits[j]);
                    end
                    esc_phase = PH_IDLE;
                    held_n    = 0;
                    fresh     = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        if (fresh) begin
            // A backslash on the final character has nothing to escape and passes.
            if (ch == ChBslash && !fin) begin
                esc_phase = PH_BSL;
            end else begin
                put_byte(outs, ch);
            end
        end
        if (fin) begin
            esc_phase = PH_IDLE;
            held_n    = 0;
        end
        if (outs.size() == 0) silent_items++;
        if (outs.size() == NumOut) full_groups++;
        foreach (outs[k]) begin
            d.data     = outs[k];
            d.run_last = (k == outs.size() - 1);
            d.str_end  = d.run_last && fin;
            pending_out.insert(pending_out.size(), d);
        end
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("%s", what);
    endtask

    // Prediction runs on every accepted input transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_decode(i_s_axis_tdata, i_s_axis_tlast);
        end
    end

    // Every accepted output transaction is compared with the oldest expected byte.
    always @(posedge i_clk) begin
        t_decoded w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            bytes_checked++;
            if (pending_out.size() == 0) begin
                note_failure($sformatf("%0t: unexpected byte %h last %b end %b", $realtime,
                                       o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser));
            end else begin
                w = pending_out.pop_front();
                if (o_m_axis_tdata !== w.data || o_m_axis_tlast !== w.run_last ||
                    o_m_axis_tuser !== w.str_end) begin
                    note_failure($sformatf(
                        "%0t: byte %h last %b end %b, expected byte %h last %b end %b",
                        $realtime, o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser,
                        w.data, w.run_last, w.str_end));
                end
            end
        end
    end

    // The receiver either takes every byte, follows a random stall pattern, or
    // holds off for a long stretch when a test asks for it.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 32 == 0) rx_pattern = 16'($urandom()) | 16'h0001;
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready = 1'b0;
        end else if (hold_request) begin
            hold_request    = 1'b0;
            hold_left       = HoldCycles - 1;
            i_m_axis_tready = 1'b0;
        end else if (rx_stalls) begin
            i_m_axis_tready = rx_pattern[rx_cycle % 16];
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    // Offers one character and returns once the block has taken it. tvalid stays
    // high afterwards so that back-to-back transactions leave no gap.
    task automatic send_char(input logic [7:0] ch, input logic fin);
        @(negedge i_clk);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = ch;
        i_s_axis_tlast  = fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_offered++;
    endtask

    task automatic send_string(input logic [7:0] s [$]);
        foreach (s[i]) send_char(s[i], i == s.size() - 1);
        strings_sent++;
    endtask

    // Withdraws the last offered character and waits for all expected bytes.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    // Appends one randomly chosen piece of escaped text to a string.
    function automatic void add_token(ref logic [7:0] s [$]);
        logic [15:0] cp;
        int          k;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                put_byte(s, 8'($urandom_range(0, 255)));
            end
            3: begin
                put_byte(s, ChBslash);
                case ($urandom_range(0, 6))
                    0: put_byte(s, ChN);
                    1: put_byte(s, ChR);
                    2: put_byte(s, ChT);
                    3: put_byte(s, ChBslash);
                    4: put_byte(s, 8'h22);       // double quote
                    5: put_byte(s, 8'h27);       // single quote
                    default: put_byte(s, 8'($urandom_range(0, 255)));
                endcase
            end
            4: begin
                cp = 16'($urandom_range(0, 255));
                put_byte(s, ChBslash);
                put_byte(s, ChX);
                put_byte(s, hex_char(cp[7:4]));
                put_byte(s, hex_char(cp[3:0]));
            end
            5, 6: begin
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range('h0000, 'h007F));
                    1: cp = 16'($urandom_range('h0080, 'h07FF));
                    2: cp = 16'($urandom_range('h0800, 'hFFFF));
                    default: begin
                        case ($urandom_range(0, 5))
                            0: cp = 16'h0000;
                            1: cp = 16'h007F;
                            2: cp = 16'h0080;
                            3: cp = 16'h07FF;
                            4: cp = 16'h0800;
                            default: cp = 16'hFFFF;
                        endcase
                    end
                endcase
                put_byte(s, ChBslash);
                put_byte(s, ChU);
                for (int j = 3; j >= 0; j--) put_byte(s, hex_char(cp[j*4 +: 4]));
            end
            7: begin
                // Escape broken off by a character that is not a hex digit.
                put_byte(s, ChBslash);
                if ($urandom_range(0, 1)) begin
                    put_byte(s, ChU);
                    k = $urandom_range(0, 3);
                end else begin
                    put_byte(s, ChX);
                    k = $urandom_range(0, 1);
                end
                repeat (k) put_byte(s, hex_char(4'($urandom_range(0, 15))));
                put_byte(s, $urandom_range(0, 2) == 0 ? ChBslash : non_hex_char());
            end
            8: begin
                repeat ($urandom_range(1, 3)) put_byte(s, 8'($urandom_range(0, 255)));
            end
            default: begin
                put_byte(s, ChBslash);
            end
        endcase
    endfunction

    // Directed tests.

    task automatic test_plain_bytes();
        send_string('{8'h00, 8'hFF});
        send_string('{8'h41});
    endtask

    task automatic test_simple_escapes();
        send_string('{ChBslash, ChN, ChBslash, ChBslash, ChBslash, 8'h71});   // \n \\ \q
    endtask

    task automatic test_hex_escapes();
        send_string('{ChBslash, ChX, 8'h34, 8'h66,
                      ChBslash, ChU, 8'h46, 8'h66, 8'h46, 8'h66});             // \x4f \uFfFf
    endtask

    task automatic test_broken_escapes();
        // Bad digit that is itself a backslash, which then starts a newline escape.
        send_string('{ChBslash, ChU, 8'h31, ChBslash, ChN});
        // String ends with one hex digit still missing.
        send_string('{ChBslash, ChX, 8'h34});
        // Escape letter as the final character.
        send_string('{ChBslash, ChU});
        // Trailing lone backslash.
        send_string('{ChBslash});
    endtask

    // The receiver holds off for a long stretch while three-byte escapes keep
    // arriving, so the queue fills and the input side must stall.
    task automatic test_backpressure();
        tx_bursty    = 1'b0;
        hold_request = 1'b1;
        repeat (8) send_string('{ChBslash, ChU, 8'h32, 8'h30, 8'h61, 8'h43});
        wait_drained();
    endtask

    task automatic test_random_strings();
        logic [7:0] s [$];
        int         start;
        start = items_offered;
        while (items_offered - start < ItemTarget) begin
            if (strings_sent % 15 == 0) begin
                tx_bursty = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            s.delete();
            repeat ($urandom_range(1, 6)) add_token(s);
            // Some strings are cut short so that escapes end early.
            if ($urandom_range(0, 4) == 0) begin
                while (s.size() > 1 && s.size() > $urandom_range(1, 8)) s.delete(s.size() - 1);
            end
            send_string(s);
        end
    endtask

    initial begin
        #(RunLimit);
        $display("backslash_escape_decoder regression: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_bytes();
        test_simple_escapes();
        rx_stalls = 1'b1;
        tx_bursty = 1'b1;
        test_hex_escapes();
        test_broken_escapes();
        test_backpressure();
        test_random_strings();

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (DrainTail) @(posedge i_clk);
        if (pending_out.size() != 0) note_failure("decoded bytes still missing at the end");

        $display("Sent %0d characters in %0d strings; checked %0d decoded bytes.",
                 items_offered, strings_sent, bytes_checked);
        $display("%0d characters gave no output, %0d gave the full group of five.",
                 silent_items, full_groups);
        if (fail_count == 0) begin
            $display("backslash_escape_decoder regression: pass");
        end else begin
            $display("%0d failures in total.", fail_count);
            $display("backslash_escape_decoder regression: fail");
        end
        $finish;
    end

endmodule
